### hw/rtl/kect_pkg.sv
// Package for the keyed event counter table.
// Holds the key width, output field widths and the control bundle that the
// top level broadcasts to every cell of the chain. No dependencies.
`default_nettype none

package kect_pkg;

  // Width of an event key.
  localparam int unsigned KeyW = 64;

  // Output field widths.
  localparam int unsigned CountOutW = 32;
  localparam int unsigned UsedOutW  = 7;

  // Input action codes.
  localparam logic ActMark  = 1'b0;
  localparam logic ActClear = 1'b1;

  // Control broadcast to the cells during the update cycle.
  typedef struct packed {
    logic upd;     // update strobe, the cycle in which cells change
    logic clear;   // invalidate every entry
    logic insert;  // key absent and room left: open a slot in order
    logic incr;    // key present: bump the matching entry
  } ctl_t;

endpackage : kect_pkg

`default_nettype wire

### hw/rtl/kect_cell.sv
// One cell of the sorted key chain: a key, a count and a valid bit.
// Depends on kect_pkg. Takes the entry of its left neighbor when an
// insert opens a slot left of this cell.
`default_nettype none

module kect_cell #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire kect_pkg::ctl_t           ctl,
  input  wire logic [kect_pkg::KeyW-1:0] search_key,
  input  wire logic [kect_pkg::KeyW-1:0] left_key,
  input  wire logic [COUNT_WIDTH-1:0]   left_count,
  input  wire logic                     left_valid,
  input  wire logic                     left_ge,
  output logic [kect_pkg::KeyW-1:0]     key,
  output logic [COUNT_WIDTH-1:0]        count,
  output logic                          valid,
  output logic                          ge,
  output logic                          hit
);

  logic [COUNT_WIDTH-1:0] count_inc;

  // Compare flags, registered every cycle from the held search key.
  // ge marks an entry that is empty or not below the key.
  always_ff @(posedge clk) begin
    ge  <= !valid || (key >= search_key);
    hit <= valid && (key == search_key);
  end

  // Saturating increment.
  assign count_inc = (count == {COUNT_WIDTH{1'b1}}) ? count : count + 1'b1;

  // Valid bit: cleared by reset and by a table clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.upd) begin
      if (ctl.clear) begin
        valid <= 1'b0;
      end else if (ctl.insert && ge) begin
        valid <= left_ge ? left_valid : 1'b1;
      end
    end
  end

  // Entry payload: shift right past the insert point, write the new key at
  // it, or bump the count of the matching entry.
  always_ff @(posedge clk) begin
    if (ctl.upd && !ctl.clear) begin
      if (ctl.insert && ge) begin
        if (left_ge) begin
          key   <= left_key;
          count <= left_count;
        end else begin
          key   <= search_key;
          count <= COUNT_WIDTH'(1);
        end
      end else if (ctl.incr && hit) begin
        count <= count_inc;
      end
    end
  end

endmodule : kect_cell

`default_nettype wire

### hw/rtl/keyed_event_counter_table.sv
// Keyed event counter table, top level.
// Depends on kect_pkg and kect_cell; builds a chain of TABLE_DEPTH cells.
//
// Use:
//   The input channel (s_tvalid/s_tready/s_tdata/s_tuser) takes one beat per
//   event. s_tuser is the action: mark the key in s_tdata, or clear the
//   table. Every input beat gives exactly one output beat on the master
//   channel (m_tvalid/m_tready/m_tdata) with the key's count after the mark,
//   new-entry and dropped flags, and the number of keys held.
//   Keys sit in the cells in ascending order. A mark compares its key in
//   every cell at once, then in the update cycle bumps the matching cell,
//   or shifts the cells at and above the insert point one place right and
//   writes the new key with count one, or drops the key if the table is full.
// Sequencing:
//   An item passes the compare state and then the update state, and its
//   result register is loaded in the update cycle. A new beat is accepted
//   in the update cycle once the result register is free.
// Reset:
//   rst empties the table; key and count contents are not cleared. s_tready
//   stays low while rst is high.
// Stall:
//   The result register holds until m_tready. A pending result does not
//   block an accept in the idle state, but that item waits in its update
//   cycle until the result register is free.
`default_nettype none

module keyed_event_counter_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [63:0] event_key
  input  wire logic        s_tuser,   // [0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // [31:0] count_after, [32] was_new,
                                      // [33] dropped, [40:34] entries_used,
                                      // [47:41] zero
);

  localparam int unsigned OccW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [kect_pkg::KeyW-1:0] search_key;
  logic                      act;
  logic [OccW-1:0]           occ;

  logic [kect_pkg::KeyW-1:0] cell_key   [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0]    cell_count [TABLE_DEPTH];
  logic                      cell_valid [TABLE_DEPTH];
  logic                      cell_ge    [TABLE_DEPTH];
  logic                      cell_hit   [TABLE_DEPTH];

  logic                   accept;
  logic                   out_free;
  logic                   hit_any;
  logic [COUNT_WIDTH-1:0] hit_count;
  logic [COUNT_WIDTH-1:0] count_new;
  logic                   full;
  logic                   drop;
  kect_pkg::ctl_t         ctl;
  logic [OccW-1:0]        occ_next;

  logic [COUNT_WIDTH+kect_pkg::CountOutW-1:0] count_ext;
  logic [OccW+kect_pkg::UsedOutW-1:0]         occ_ext;

  // Handshake: take a beat when idle, or in the update cycle once the
  // result register can take this item's result.
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !rst && ((state == ST_IDLE) || ((state == ST_UPD) && out_free));
  assign accept   = s_tvalid && s_tready;

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) state_next = accept ? ST_EVAL : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Held item.
  always_ff @(posedge clk) begin
    if (accept) begin
      search_key <= s_tdata;
      act        <= s_tuser;
    end
  end

  // Gather the compare flags and the count of the matching cell.
  always_comb begin
    hit_any   = 1'b0;
    hit_count = '0;
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      hit_any   = hit_any | cell_hit[i];
      hit_count = hit_count | (cell_hit[i] ? cell_count[i] : '0);
    end
  end

  assign full      = (occ == OccW'(TABLE_DEPTH));
  assign drop      = !hit_any && full;
  assign count_new = (hit_count == {COUNT_WIDTH{1'b1}}) ? hit_count : hit_count + 1'b1;

  // Control for the update cycle.
  always_comb begin
    ctl.upd    = (state == ST_UPD) && out_free;
    ctl.clear  = (act == kect_pkg::ActClear);
    ctl.insert = (act == kect_pkg::ActMark) && !hit_any && !full;
    ctl.incr   = (act == kect_pkg::ActMark) && hit_any;
  end

  // Occupancy.
  always_comb begin
    occ_next = occ;
    if (ctl.clear) begin
      occ_next = '0;
    end else if (ctl.insert) begin
      occ_next = occ + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (ctl.upd) begin
      occ <= occ_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.upd) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign occ_ext = {{kect_pkg::UsedOutW{1'b0}}, occ_next};

  always_comb begin
    count_ext = '0;
    if (ctl.incr) begin
      count_ext = {{kect_pkg::CountOutW{1'b0}}, count_new};
    end else if (ctl.insert) begin
      count_ext = (COUNT_WIDTH + kect_pkg::CountOutW)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      m_tdata[31:0]  <= count_ext[kect_pkg::CountOutW-1:0];
      m_tdata[32]    <= ctl.insert && !ctl.clear;
      m_tdata[33]    <= drop && !ctl.clear;
      m_tdata[40:34] <= occ_ext[kect_pkg::UsedOutW-1:0];
      m_tdata[47:41] <= '0;
    end
  end

  // Chain of cells, each fed by its left neighbor.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [kect_pkg::KeyW-1:0] lk;
    logic [COUNT_WIDTH-1:0]    lc;
    logic                      lv;
    logic                      lg;

    if (i == 0) begin : g_head
      assign lk = '0;
      assign lc = '0;
      assign lv = 1'b0;
      assign lg = 1'b0;
    end else begin : g_body
      assign lk = cell_key[i-1];
      assign lc = cell_count[i-1];
      assign lv = cell_valid[i-1];
      assign lg = cell_ge[i-1];
    end

    kect_cell #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .search_key (search_key),
      .left_key   (lk),
      .left_count (lc),
      .left_valid (lv),
      .left_ge    (lg),
      .key        (cell_key[i]),
      .count      (cell_count[i]),
      .valid      (cell_valid[i]),
      .ge         (cell_ge[i]),
      .hit        (cell_hit[i])
    );
  end

endmodule : keyed_event_counter_table

`default_nettype wire
